### hw/rtl/gsc_pkg.sv
// Shared types, constants and lookup functions for the synced clock display core.
// Standalone package; every other file in hw/rtl imports it.
package gsc_pkg;

    // Request codes on req_type
    localparam logic [1:0] REQ_BYTE = 2'd0;
    localparam logic [1:0] REQ_TICK = 2'd1;
    localparam logic [1:0] REQ_SCAN = 2'd2;

    // Display scan
    localparam int SCAN_POSITIONS = 9;
    localparam int SCAN_W         = 4;
    localparam logic [SCAN_W-1:0] SCAN_LAST  = SCAN_W'(SCAN_POSITIONS - 1);
    localparam logic [SCAN_W-1:0] SCAN_SHIFT = SCAN_W'(8);

    // Sentence matcher
    localparam logic [3:0] PREFIX_LEN = 4'd7;
    localparam logic [3:0] DIGIT_END  = 4'd13;
    localparam int         NUM_DIGITS = 6;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    // Clock limits and reset value
    localparam logic [4:0] HOUR_MAX   = 5'd23;
    localparam logic [5:0] MINSEC_MAX = 6'd59;
    localparam logic [4:0] HOUR_INIT  = 5'd21;
    localparam logic [5:0] MIN_INIT   = 6'd37;
    localparam logic [5:0] SEC_INIT   = 6'd0;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        OP_REPORT,
        OP_LOAD,
        OP_TICK,
        OP_SCAN
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [4:0] hours;
        logic [5:0] minutes;
        logic [5:0] seconds;
    } cmd_t;

    function automatic logic [7:0] prefix_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h24; // '$'
            3'd1:    c = 8'h47; // 'G'
            3'd2:    c = 8'h50; // 'P'
            3'd3:    c = 8'h52; // 'R'
            3'd4:    c = 8'h4D; // 'M'
            3'd5:    c = 8'h43; // 'C'
            3'd6:    c = 8'h2C; // ','
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // Segments a..g in bits 7..1, decimal point in bit 0
    function automatic logic [7:0] seg_font(input logic [3:0] digit);
        logic [7:0] s;
        case (digit)
            4'd0:    s = 8'b11111100;
            4'd1:    s = 8'b01100000;
            4'd2:    s = 8'b11011010;
            4'd3:    s = 8'b11110010;
            4'd4:    s = 8'b01100110;
            4'd5:    s = 8'b10110110;
            4'd6:    s = 8'b10111110;
            4'd7:    s = 8'b11100000;
            4'd8:    s = 8'b11111110;
            4'd9:    s = 8'b11110110;
            default: s = 8'b00000000;
        endcase
        return s;
    endfunction

    // Tens digit of a value 0..63 by comparison
    function automatic logic [3:0] dec_tens(input logic [5:0] v);
        logic [3:0] t;
        if (v >= 6'd60)      t = 4'd6;
        else if (v >= 6'd50) t = 4'd5;
        else if (v >= 6'd40) t = 4'd4;
        else if (v >= 6'd30) t = 4'd3;
        else if (v >= 6'd20) t = 4'd2;
        else if (v >= 6'd10) t = 4'd1;
        else                 t = 4'd0;
        return t;
    endfunction

    function automatic logic [3:0] dec_ones(input logic [5:0] v);
        logic [3:0] t;
        logic [5:0] r;
        t = dec_tens(v);
        r = v - ({2'b00, t} * 6'd10);
        return r[3:0];
    endfunction

endpackage

### hw/rtl/gsc_front.sv
// Front end: accepts request transactions, runs the sentence matcher and
// turns each request into a command for the queue. Depends on gsc_pkg.
module gsc_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [1:0]    req_type,
    input  logic [7:0]    rx_byte,
    input  logic          q_full,
    output logic          q_push,
    output gsc_pkg::cmd_t q_cmd
);
    import gsc_pkg::*;

    logic [3:0] progress_reg, progress_next;
    logic [3:0] digits_reg [NUM_DIGITS];
    logic [3:0] digits_next [NUM_DIGITS];
    logic [2:0] digit_idx;
    logic [3:0] digit_off;
    logic [6:0] h_val, m_val, s_val;
    logic       accept;
    logic       is_digit;
    cmd_t       cmd;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign q_push   = accept;
    assign q_cmd    = cmd;

    assign digit_off = progress_reg - PREFIX_LEN;
    assign digit_idx = digit_off[2:0];
    assign is_digit  = (rx_byte >= CHAR_ZERO) && (rx_byte <= CHAR_NINE);

    assign h_val = 7'(digits_reg[0]) * 7'd10 + 7'(digits_reg[1]);
    assign m_val = 7'(digits_reg[2]) * 7'd10 + 7'(digits_reg[3]);
    assign s_val = 7'(digits_reg[4]) * 7'd10 + 7'(digits_reg[5]);

    always_comb
    begin
        progress_next = progress_reg;
        digits_next   = digits_reg;
        cmd.op        = OP_REPORT;
        cmd.hours     = h_val[4:0];
        cmd.minutes   = m_val[5:0];
        cmd.seconds   = s_val[5:0];
        case (req_type)
            REQ_BYTE:
            begin
                if (progress_reg < PREFIX_LEN)
                begin
                    progress_next = (rx_byte == prefix_char(progress_reg[2:0]))
                                    ? progress_reg + 4'd1 : 4'd0;
                end
                else if (progress_reg < DIGIT_END)
                begin
                    if (is_digit)
                    begin
                        digits_next[digit_idx] = rx_byte[3:0];
                        progress_next          = progress_reg + 4'd1;
                    end
                    else
                    begin
                        progress_next = 4'd0;
                    end
                end
                else
                begin
                    // load only a complete sentence with an in-range time
                    if (progress_reg == DIGIT_END && rx_byte == CHAR_DOT &&
                        h_val <= 7'(HOUR_MAX) && m_val <= 7'(MINSEC_MAX) &&
                        s_val <= 7'(MINSEC_MAX))
                    begin
                        cmd.op = OP_LOAD;
                    end
                    progress_next = 4'd0;
                end
            end
            REQ_TICK: cmd.op = OP_TICK;
            REQ_SCAN: cmd.op = OP_SCAN;
            default:  cmd.op = OP_REPORT;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            progress_reg <= 4'd0;
            for (int i = 0; i < NUM_DIGITS; i++)
            begin
                digits_reg[i] <= 4'd0;
            end
        end
        else if (accept)
        begin
            progress_reg <= progress_next;
            digits_reg   <= digits_next;
        end
    end

endmodule

### hw/rtl/gsc_queue.sv
// Short command queue that decouples the front end from the back end.
// Depends on gsc_pkg for the command type and depth.
module gsc_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  gsc_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output logic          not_empty,
    output gsc_pkg::cmd_t head_cmd
);
    import gsc_pkg::*;

    cmd_t                mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CW-1:0] count_reg, count_next;

    localparam logic [QUEUE_AW-1:0] PTR_LAST = QUEUE_AW'(QUEUE_DEPTH - 1);
    localparam logic [QUEUE_CW-1:0] CNT_FULL = QUEUE_CW'(QUEUE_DEPTH);

    assign full      = (count_reg == CNT_FULL);
    assign not_empty = (count_reg != '0);
    assign head_cmd  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### hw/rtl/gsc_back.sv
// Back end: executes queued commands against the time-of-day counters and
// display scan, and holds the result in an output register. Depends on gsc_pkg.
module gsc_back (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      q_not_empty,
    input  gsc_pkg::cmd_t             q_cmd,
    output logic                      q_pop,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [4:0]                hours,
    output logic [5:0]                minutes,
    output logic [5:0]                seconds,
    output logic                      time_loaded,
    output logic [7:0]                segments,
    output logic                      shift_data,
    output logic [gsc_pkg::SCAN_W-1:0] scan_index
);
    import gsc_pkg::*;

    logic [4:0]        hour_reg, hour_next;
    logic [5:0]        min_reg, min_next;
    logic [5:0]        sec_reg, sec_next;
    logic [SCAN_W-1:0] scan_reg, scan_next;

    logic              out_valid_reg, out_valid_next;
    logic              loaded_reg, loaded_next;
    logic [7:0]        seg_reg, seg_next;
    logic              sdata_reg, sdata_next;
    logic [SCAN_W-1:0] sidx_reg, sidx_next;
    logic [5:0]        disp_val;
    logic [7:0]        pattern;

    assign q_pop = q_not_empty && (!out_valid_reg || out_ready);

    // value shown at the current scan position
    always_comb
    begin
        case (scan_reg)
            SCAN_W'(1), SCAN_W'(2): disp_val = {1'b0, hour_reg};
            SCAN_W'(3), SCAN_W'(4): disp_val = min_reg;
            SCAN_W'(5), SCAN_W'(6): disp_val = sec_reg;
            default:                disp_val = 6'd0;
        endcase
        case (scan_reg)
            SCAN_W'(1), SCAN_W'(3), SCAN_W'(5): pattern = seg_font(dec_tens(disp_val));
            SCAN_W'(2), SCAN_W'(4), SCAN_W'(6): pattern = seg_font(dec_ones(disp_val));
            default:                            pattern = 8'd0;
        endcase
    end

    always_comb
    begin
        hour_next   = hour_reg;
        min_next    = min_reg;
        sec_next    = sec_reg;
        scan_next   = scan_reg;
        loaded_next = 1'b0;
        seg_next    = 8'd0;
        sdata_next  = 1'b0;
        sidx_next   = '0;
        case (q_cmd.op)
            OP_LOAD:
            begin
                hour_next   = q_cmd.hours;
                min_next    = q_cmd.minutes;
                sec_next    = q_cmd.seconds;
                loaded_next = 1'b1;
            end
            OP_TICK:
            begin
                if (sec_reg >= MINSEC_MAX)
                begin
                    sec_next = 6'd0;
                    if (min_reg >= MINSEC_MAX)
                    begin
                        min_next  = 6'd0;
                        hour_next = (hour_reg >= HOUR_MAX) ? 5'd0 : hour_reg + 5'd1;
                    end
                    else
                    begin
                        min_next = min_reg + 6'd1;
                    end
                end
                else
                begin
                    sec_next = sec_reg + 6'd1;
                end
            end
            OP_SCAN:
            begin
                seg_next = pattern;
                if (scan_reg == SCAN_W'(2) || scan_reg == SCAN_W'(4))
                begin
                    seg_next[0] = 1'b1;
                end
                sdata_next = (scan_reg == SCAN_SHIFT);
                sidx_next  = scan_reg;
                scan_next  = (scan_reg >= SCAN_LAST) ? '0 : scan_reg + 1'b1;
            end
            default:
            begin
                loaded_next = 1'b0;
            end
        endcase
        out_valid_next = q_pop ? 1'b1 : (out_valid_reg && !out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hour_reg      <= HOUR_INIT;
            min_reg       <= MIN_INIT;
            sec_reg       <= SEC_INIT;
            scan_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (q_pop)
            begin
                hour_reg <= hour_next;
                min_reg  <= min_next;
                sec_reg  <= sec_next;
                scan_reg <= scan_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            loaded_reg <= loaded_next;
            seg_reg    <= seg_next;
            sdata_reg  <= sdata_next;
            sidx_reg   <= sidx_next;
        end
    end

    // clock fields track the counters, which change only on a pop
    assign out_valid   = out_valid_reg;
    assign hours       = hour_reg;
    assign minutes     = min_reg;
    assign seconds     = sec_reg;
    assign time_loaded = loaded_reg;
    assign segments    = seg_reg;
    assign shift_data  = sdata_reg;
    assign scan_index  = sidx_reg;

endmodule

### hw/rtl/gps_synced_clock_display_core.sv
// Top level of the GPS-synced time-of-day clock and display scanner.
// Instantiates gsc_front, gsc_queue and gsc_back; depends on gsc_pkg.
//
// The core keeps hours, minutes and seconds (reset 21:37:00) and handles one
// request transaction at a time from a valid/ready input: a received UART
// byte (req_type 0), a one-second tick (1) or a display scan tick (2); code 3
// just reports the time. Bytes feed a matcher for "$GPRMC," plus six digits
// and '.', which loads hhmmss when in range and flags time_loaded. Each
// request yields exactly one result transaction carrying the time after the
// request, plus the seven-segment pattern, shift data bit and scan position
// on scan ticks. An accepted request passes through the matcher front end into
// the two-entry command queue, then through the back end into the output
// register. Sustained rate is one transaction per cycle while out_ready is
// high; the two-entry queue absorbs input while the output stalls until it
// fills, after which in_ready drops until results drain.
module gps_synced_clock_display_core (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [1:0]                 req_type,
    input  logic [7:0]                 rx_byte,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [4:0]                 hours,
    output logic [5:0]                 minutes,
    output logic [5:0]                 seconds,
    output logic                       time_loaded,
    output logic [7:0]                 segments,
    output logic                       shift_data,
    output logic [gsc_pkg::SCAN_W-1:0] scan_index
);
    import gsc_pkg::*;

    logic q_full;
    logic q_push;
    logic q_pop;
    logic q_not_empty;
    cmd_t push_cmd;
    cmd_t head_cmd;

    // Classify requests and track sentence progress
    gsc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .req_type (req_type),
        .rx_byte  (rx_byte),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (push_cmd)
    );

    // Hold commands so either side can stall on its own
    gsc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_cmd  (push_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_cmd  (head_cmd)
    );

    // Advance the clock, drive the display and register each result
    gsc_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_cmd       (head_cmd),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .hours       (hours),
        .minutes     (minutes),
        .seconds     (seconds),
        .time_loaded (time_loaded),
        .segments    (segments),
        .shift_data  (shift_data),
        .scan_index  (scan_index)
    );

    // Reported time always stays within the clock range
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (hours <= HOUR_MAX && minutes <= MINSEC_MAX &&
                       seconds <= MINSEC_MAX))
        else $error("reported time out of range");

    // A time load never coincides with display output
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && time_loaded) |-> (segments == 8'd0 && !shift_data &&
                                        scan_index == '0))
        else $error("time load carries display fields");

    // Shift data marks the shift position only
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && shift_data) |-> (scan_index == SCAN_SHIFT))
        else $error("shift data outside its scan position");

    // Nothing is pushed into a full queue
    assert property (@(posedge clk) disable iff (!rst_n)
        q_full |-> !q_push)
        else $error("push into full command queue");

endmodule

### tb/sv/tb_gps_synced_clock_display_core.sv
`timescale 1ns / 100ps
// Self-checking testbench for gps_synced_clock_display_core: sentence loads, ticks, scan.
// Depends on gsc_pkg and the core RTL; predicts results with an in-bench clock model.
module tb_gps_synced_clock_display_core;

    import gsc_pkg::*;

    // Unused request code: the core only reports the time for it
    localparam logic [1:0] REQ_NONE = 2'd3;

    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int DRAIN_CYCLES    = 16;
    localparam int ITEMS_PER_PHASE = 370;
    localparam int DIRECTED_ROWS   = 25;

    // Sentence header "$GPRMC," as the matcher expects it, byte by byte
    localparam logic [7:0] GPRMC_TAG [7] = '{
        8'h24, 8'h47, 8'h50, 8'h52, 8'h4D, 8'h43, 8'h2C
    };

    // Seven-segment patterns for digits 0..9, a..g in bits 7..1
    localparam logic [7:0] DIGIT_SEGS [10] = '{
        8'hFC, 8'h60, 8'hDA, 8'hF2, 8'h66, 8'hB6, 8'hBE, 8'hE0, 8'hFE, 8'hF6
    };

    typedef struct packed {
        logic [4:0]        hours;
        logic [5:0]        minutes;
        logic [5:0]        seconds;
        logic              loaded;
        logic [7:0]        segs;
        logic              shift;
        logic [SCAN_W-1:0] idx;
    } display_res_t;

    typedef struct packed {
        logic [1:0]   req;
        logic [7:0]   rx;
        logic         typed;
        display_res_t want;
    } stim_row_t;

    // Directed opening. Rows with typed set carry a hand-written result; the rest
    // fall back to the clock model. The sentence sets 23:59:59 so the following
    // tick rolls every counter over at once.
    localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
        '{REQ_SCAN, 8'h00, 1'b1, '{5'd21, 6'd37, 6'd0, 1'b0, 8'h00, 1'b0, 4'd0}},
        '{REQ_SCAN, 8'hFF, 1'b1, '{5'd21, 6'd37, 6'd0, 1'b0, 8'hDA, 1'b0, 4'd1}},
        '{REQ_SCAN, 8'h00, 1'b1, '{5'd21, 6'd37, 6'd0, 1'b0, 8'h61, 1'b0, 4'd2}},
        '{REQ_NONE, 8'hFF, 1'b1, '{5'd21, 6'd37, 6'd0, 1'b0, 8'h00, 1'b0, 4'd0}},
        '{REQ_BYTE, 8'h00, 1'b1, '{5'd21, 6'd37, 6'd0, 1'b0, 8'h00, 1'b0, 4'd0}},
        '{REQ_TICK, 8'hFF, 1'b1, '{5'd21, 6'd37, 6'd1, 1'b0, 8'h00, 1'b0, 4'd0}},
        '{REQ_BYTE, GPRMC_TAG[0], 1'b0, '0},
        '{REQ_BYTE, GPRMC_TAG[1], 1'b0, '0},
        '{REQ_BYTE, GPRMC_TAG[2], 1'b0, '0},
        '{REQ_BYTE, GPRMC_TAG[3], 1'b0, '0},
        '{REQ_BYTE, GPRMC_TAG[4], 1'b0, '0},
        '{REQ_BYTE, GPRMC_TAG[5], 1'b0, '0},
        '{REQ_BYTE, GPRMC_TAG[6], 1'b0, '0},
        '{REQ_BYTE, 8'h32, 1'b0, '0},
        '{REQ_BYTE, 8'h33, 1'b0, '0},
        '{REQ_BYTE, 8'h35, 1'b0, '0},
        '{REQ_BYTE, 8'h39, 1'b0, '0},
        '{REQ_BYTE, 8'h35, 1'b0, '0},
        '{REQ_BYTE, 8'h39, 1'b0, '0},
        '{REQ_BYTE, CHAR_DOT, 1'b1, '{5'd23, 6'd59, 6'd59, 1'b1, 8'h00, 1'b0, 4'd0}},
        '{REQ_TICK, 8'h00, 1'b1, '{5'd0, 6'd0, 6'd0, 1'b0, 8'h00, 1'b0, 4'd0}},
        '{REQ_BYTE, 8'hFF, 1'b0, '0},
        '{REQ_SCAN, 8'h00, 1'b0, '0},
        '{REQ_SCAN, 8'h00, 1'b0, '0},
        '{REQ_SCAN, 8'h00, 1'b0, '0}
    };

    // Block interface; every input starts at a known value
    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    logic                in_ready;
    logic [1:0]          req_type  = REQ_BYTE;
    logic [7:0]          rx_byte   = 8'h00;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [4:0]          hours;
    logic [5:0]          minutes;
    logic [5:0]          seconds;
    logic                time_loaded;
    logic [7:0]          segments;
    logic                shift_data;
    logic [SCAN_W-1:0]   scan_index;

    // Handshake flags, settled at the falling edge ahead of the edge that uses them
    logic in_take  = 1'b0;
    logic out_take = 1'b0;

    // Pacing: percentage of cycles each side holds back
    int snd_idle_pct = 32;
    int rcv_idle_pct = 49;

    // Clock model state
    logic [4:0]        clk_hours;
    logic [5:0]        clk_minutes;
    logic [5:0]        clk_seconds;
    logic [3:0]        sync_progress;
    logic [3:0]        sync_digits [6];
    logic [SCAN_W-1:0] scan_pos;

    // Results still owed by the core, oldest first
    display_res_t clock_expect [$];

    int fault_count     = 0;
    int results_checked = 0;
    int items_sent      = 0;
    int loads_done      = 0;
    int loads_dropped   = 0;
    int ticks_sent      = 0;
    int scans_sent      = 0;
    int stall_cycles    = 0;

    gps_synced_clock_display_core i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .req_type    (req_type),
        .rx_byte     (rx_byte),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .hours       (hours),
        .minutes     (minutes),
        .seconds     (seconds),
        .time_loaded (time_loaded),
        .segments    (segments),
        .shift_data  (shift_data),
        .scan_index  (scan_index)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report_fault(input string msg);
        $display("[%0t] result %0d: %s", $realtime, results_checked, msg);
        fault_count++;
    endtask

    // Advance the clock model by one request and return the result it owes
    task automatic step_clock_model(input logic [1:0] req, input logic [7:0] rx,
                                    output display_res_t res);
        int h;
        int m;
        int s;
        res = '0;
        case (req)
            REQ_BYTE:
            begin
                if (sync_progress < PREFIX_LEN)
                begin
                    // A wrong byte drops the match; it is never retried as a '$'
                    sync_progress = (rx == GPRMC_TAG[sync_progress]) ?
                                    sync_progress + 4'd1 : 4'd0;
                end
                else if (sync_progress < DIGIT_END)
                begin
                    if (rx >= CHAR_ZERO && rx <= CHAR_NINE)
                    begin
                        sync_digits[sync_progress - PREFIX_LEN] = 4'(rx - CHAR_ZERO);
                        sync_progress = sync_progress + 4'd1;
                    end
                    else
                        sync_progress = 4'd0;
                end
                else
                begin
                    // Only a '.' right after the six digits may load the time
                    if (sync_progress == DIGIT_END && rx == CHAR_DOT)
                    begin
                        h = sync_digits[0] * 10 + sync_digits[1];
                        m = sync_digits[2] * 10 + sync_digits[3];
                        s = sync_digits[4] * 10 + sync_digits[5];
                        if (h <= HOUR_MAX && m <= MINSEC_MAX && s <= MINSEC_MAX)
                        begin
                            clk_hours   = 5'(h);
                            clk_minutes = 6'(m);
                            clk_seconds = 6'(s);
                            res.loaded  = 1'b1;
                            loads_done++;
                        end
                        else
                            loads_dropped++;
                    end
                    sync_progress = 4'd0;
                end
            end
            REQ_TICK:
            begin
                ticks_sent++;
                if (clk_seconds < MINSEC_MAX)
                    clk_seconds = clk_seconds + 6'd1;
                else
                begin
                    clk_seconds = 6'd0;
                    if (clk_minutes < MINSEC_MAX)
                        clk_minutes = clk_minutes + 6'd1;
                    else
                    begin
                        clk_minutes = 6'd0;
                        clk_hours = (clk_hours < HOUR_MAX) ? clk_hours + 5'd1 : 5'd0;
                    end
                end
            end
            REQ_SCAN:
            begin
                scans_sent++;
                case (scan_pos)
                    4'd1:    res.segs = DIGIT_SEGS[clk_hours / 10];
                    4'd2:    res.segs = DIGIT_SEGS[clk_hours % 10];
                    4'd3:    res.segs = DIGIT_SEGS[clk_minutes / 10];
                    4'd4:    res.segs = DIGIT_SEGS[clk_minutes % 10];
                    4'd5:    res.segs = DIGIT_SEGS[clk_seconds / 10];
                    4'd6:    res.segs = DIGIT_SEGS[clk_seconds % 10];
                    default: res.segs = 8'h00;
                endcase
                if (scan_pos == 4'd2 || scan_pos == 4'd4)
                    res.segs[0] = 1'b1;
                res.shift = (scan_pos == SCAN_SHIFT);
                res.idx   = scan_pos;
                scan_pos  = (scan_pos == SCAN_LAST) ? '0 : scan_pos + 1'b1;
            end
            default: ;
        endcase
        res.hours   = clk_hours;
        res.minutes = clk_minutes;
        res.seconds = clk_seconds;
    endtask

    // Offer one request, hold it until taken, then log what the core owes for it
    task automatic send_item(input logic [1:0] req, input logic [7:0] rx,
                             input logic typed = 1'b0, input display_res_t want = '0);
        display_res_t predicted;
        while (snd_idle_pct != 0 && $urandom_range(99) < snd_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= req;
        rx_byte  <= rx;
        @(posedge clk);
        while (!in_take)
            @(posedge clk);
        step_clock_model(req, rx, predicted);
        clock_expect.push_back(typed ? want : predicted);
        items_sent++;
    endtask

    // Hold the sender off until every owed result has been taken
    task automatic await_all_results();
        in_valid <= 1'b0;
        while (clock_expect.size() != 0)
            @(posedge clk);
    endtask

    // Random traffic: mostly whole sentences with random content, plus tick runs,
    // scan runs and plain noise across every request code and byte value
    task automatic run_random_phase(input int count);
        int         stop_at;
        int         pick;
        int         hh;
        int         mm;
        int         ss;
        logic [7:0] sentence [14];
        stop_at = items_sent + count;
        while (items_sent < stop_at)
        begin
            pick = $urandom_range(99);
            if (pick < 50)
            begin
                hh = $urandom_range(23);
                mm = $urandom_range(59);
                ss = $urandom_range(59);
                pick = $urandom_range(99);
                if (pick >= 85)
                begin
                    // Any two digits per field: often out of range
                    hh = $urandom_range(99);
                    mm = $urandom_range(99);
                    ss = $urandom_range(99);
                end
                else if (pick >= 60)
                begin
                    // Just short of midnight so ticks soon roll the hour over
                    hh = 23;
                    mm = 59;
                    ss = $urandom_range(59, 45);
                end
                for (int i = 0; i < 7; i++)
                    sentence[i] = GPRMC_TAG[i];
                sentence[7]  = CHAR_ZERO + 8'(hh / 10);
                sentence[8]  = CHAR_ZERO + 8'(hh % 10);
                sentence[9]  = CHAR_ZERO + 8'(mm / 10);
                sentence[10] = CHAR_ZERO + 8'(mm % 10);
                sentence[11] = CHAR_ZERO + 8'(ss / 10);
                sentence[12] = CHAR_ZERO + 8'(ss % 10);
                sentence[13] = ($urandom_range(99) < 85) ? CHAR_DOT : 8'($urandom);
                // Break the odd sentence somewhere along its length
                if ($urandom_range(99) < 10)
                    sentence[$urandom_range(13)] = 8'($urandom);
                // A stray '$' ahead of the header spoils the match
                if ($urandom_range(99) < 5)
                    send_item(REQ_BYTE, GPRMC_TAG[0]);
                for (int i = 0; i < 14; i++)
                begin
                    if ($urandom_range(99) < 5)
                        send_item($urandom_range(1) ? REQ_TICK : REQ_SCAN, 8'($urandom));
                    send_item(REQ_BYTE, sentence[i]);
                end
            end
            else if (pick < 68)
                repeat ($urandom_range(70, 1)) send_item(REQ_TICK, 8'($urandom));
            else if (pick < 86)
                repeat ($urandom_range(12, 1)) send_item(REQ_SCAN, 8'($urandom));
            else
                repeat ($urandom_range(6, 1)) send_item(2'($urandom), 8'($urandom));
        end
    endtask

    // Receiver: hold out_ready low for the current share of cycles
    always @(posedge clk)
    begin
        out_ready <= rst_n && ($urandom_range(99) >= rcv_idle_pct);
    end

    // Sample both handshakes at the falling edge, where every signal is settled,
    // check each result transaction against the oldest owed result, and end the
    // run if nothing moves for too long.
    always @(negedge clk)
    begin : result_monitor
        display_res_t seen;
        display_res_t want;
        in_take  = rst_n && in_valid && in_ready;
        out_take = rst_n && out_valid && out_ready;
        if (out_take)
        begin
            seen = '{hours, minutes, seconds, time_loaded, segments, shift_data, scan_index};
            if (clock_expect.size() == 0)
                report_fault("result transaction with nothing owed");
            else
            begin
                want = clock_expect.pop_front();
                results_checked++;
                if (seen.hours !== want.hours)
                    report_fault($sformatf("hours %0d, expected %0d", seen.hours, want.hours));
                if (seen.minutes !== want.minutes)
                    report_fault($sformatf("minutes %0d, expected %0d",
                                           seen.minutes, want.minutes));
                if (seen.seconds !== want.seconds)
                    report_fault($sformatf("seconds %0d, expected %0d",
                                           seen.seconds, want.seconds));
                if (seen.loaded !== want.loaded)
                    report_fault($sformatf("time_loaded %0b, expected %0b",
                                           seen.loaded, want.loaded));
                if (seen.segs !== want.segs)
                    report_fault($sformatf("segments %08b, expected %08b",
                                           seen.segs, want.segs));
                if (seen.shift !== want.shift)
                    report_fault($sformatf("shift_data %0b, expected %0b",
                                           seen.shift, want.shift));
                if (seen.idx !== want.idx)
                    report_fault($sformatf("scan_index %0d, expected %0d",
                                           seen.idx, want.idx));
            end
        end
        if (!rst_n || in_take || out_take)
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("no transaction for %0d cycles, %0d results still owed",
                     stall_cycles, clock_expect.size());
            $display("tb_gps_synced_clock_display_core: FAIL");
            $finish;
        end
    end

    initial
    begin : stimulus
        // Clock model starts where the core comes out of reset
        clk_hours     = HOUR_INIT;
        clk_minutes   = MIN_INIT;
        clk_seconds   = SEC_INIT;
        sync_progress = 4'd0;
        scan_pos      = '0;
        foreach (sync_digits[i])
            sync_digits[i] = 4'd0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table, under the first pacing
        for (int r = 0; r < DIRECTED_ROWS; r++)
            send_item(DIRECTED[r].req, DIRECTED[r].rx, DIRECTED[r].typed, DIRECTED[r].want);

        // Sender idle share 32 percent, receiver 49 percent
        run_random_phase(ITEMS_PER_PHASE);
        await_all_results();

        // Swap the pacing round
        snd_idle_pct = 49;
        rcv_idle_pct <= 32;
        run_random_phase(ITEMS_PER_PHASE);
        await_all_results();

        // Neither side idles: back-to-back transactions
        snd_idle_pct = 0;
        rcv_idle_pct <= 0;
        run_random_phase(ITEMS_PER_PHASE);
        await_all_results();

        // Let any stray result surface before the verdict
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d requests: %0d time loads, %0d out-of-range sentences dropped,",
                 items_sent, loads_done, loads_dropped);
        $display("%0d second ticks and %0d scan ticks; %0d results checked over three pacings",
                 ticks_sent, scans_sent, results_checked);
        if (fault_count == 0)
            $display("tb_gps_synced_clock_display_core: PASS");
        else
            $display("tb_gps_synced_clock_display_core: FAIL");
        $finish;
    end

endmodule
